// ===== rtl/core/szp_pkg.sv =====
// ----------------------------------------------------------------------------
// szp_pkg: shared types and constants for the size string parser
// Holds the character classes, the parse phases, the status codes and the
// structure of one classified request as it travels from the front to the back.
// ----------------------------------------------------------------------------
package szp_pkg;

   // Width of the internal value and of the result port.
   localparam int VALUE_BITS  = 64;
   localparam int SIZE_BITS   = 64;
   localparam int STATUS_BITS = 2;
   localparam int CHAR_BITS   = 8;
   localparam int DIGIT_BITS  = 4;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Shift amounts for the binary suffixes.
   localparam int SHIFT_K = 10;
   localparam int SHIFT_M = 20;
   localparam int SHIFT_G = 30;

   // Character codes that the parser recognizes.
   localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_K     = 8'h6B;
   localparam logic [CHAR_BITS-1:0] CH_M     = 8'h4D;
   localparam logic [CHAR_BITS-1:0] CH_G     = 8'h47;
   localparam logic [CHAR_BITS-1:0] CH_B     = 8'h42;

   // Class of one input byte, as decided by the front.
   typedef enum logic [3:0] {
      CLS_NUL,
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_K,
      CLS_M,
      CLS_G,
      CLS_B,
      CLS_OTHER
   } char_class_type;

   // Parse phases of the back.
   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS,
      PH_TRAIL,
      PH_SUFFIX,
      PH_BYTE,
      PH_DONE
   } phase_type;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK         = 2'd0,
      ST_NO_DIGITS  = 2'd1,
      ST_TOO_LARGE  = 2'd2,
      ST_BAD_SUFFIX = 2'd3
   } status_type;

   // One classified request.
   typedef struct packed {
      char_class_type        cls;
      logic [DIGIT_BITS-1:0] digit;
      logic                  last;
   } szp_item_type;

   // Fold saturation and sign into a finished digit run.
   function automatic logic [VALUE_BITS-1:0] close_value(
      input logic [VALUE_BITS-1:0] acc,
      input logic                  sat,
      input logic                  neg
   );
      logic [VALUE_BITS-1:0] res;
      if (sat) begin
         res = {VALUE_BITS{1'b1}};
      end else if (neg) begin
         res = '0 - acc;
      end else begin
         res = acc;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/szp_front.sv =====
// ----------------------------------------------------------------------------
// szp_front: request intake and byte classification
// Accepts one byte per cycle while the queue keeps taking requests, sorts it into
// a character class and holds the classified request in a register until the queue takes it.
// ----------------------------------------------------------------------------
module szp_front
   import szp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CHAR_BITS-1:0] req_char_in,
   input  logic                 req_last_char,
   output logic                 fr_valid,
   input  logic                 fr_ready,
   output szp_item_type         fr_item
);

   logic         valid_ff;
   logic         valid_in;
   szp_item_type item_ff;
   szp_item_type item_in;
   logic         take;

   // The stage takes a new request whenever it is empty or drains this cycle.
   assign req_ready = !valid_ff || fr_ready;
   assign take      = req_valid && req_ready;

   // Classify the incoming byte.
   always_comb begin
      item_in.digit = req_char_in[DIGIT_BITS-1:0];
      item_in.last  = req_last_char;
      unique case (req_char_in) inside
         CH_NUL:                  item_in.cls = CLS_NUL;
         [CH_TAB:CH_CR], CH_SPACE: item_in.cls = CLS_SPACE;
         CH_PLUS:                 item_in.cls = CLS_PLUS;
         CH_MINUS:                item_in.cls = CLS_MINUS;
         [CH_ZERO:CH_NINE]:       item_in.cls = CLS_DIGIT;
         CH_K:                    item_in.cls = CLS_K;
         CH_M:                    item_in.cls = CLS_M;
         CH_G:                    item_in.cls = CLS_G;
         CH_B:                    item_in.cls = CLS_B;
         default:                 item_in.cls = CLS_OTHER;
      endcase
   end

   // Occupancy of the stage register.
   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (fr_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register loads only when a request is taken.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign fr_valid = valid_ff;
   assign fr_item  = item_ff;

endmodule

// ===== rtl/core/szp_queue.sv =====
// ----------------------------------------------------------------------------
// szp_queue: short request queue between front and back
// A small first-in first-out buffer that lets the front keep taking requests
// while the back waits on the result channel.
// ----------------------------------------------------------------------------
module szp_queue
   import szp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  szp_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output szp_item_type pop_item
);

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   PTR_LAST   = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(QUEUE_DEPTH);

   szp_item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (count_ff != COUNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/szp_back.sv =====
// ----------------------------------------------------------------------------
// szp_back: parse state machine and value datapath
// Steps the parse phase once per classified request, accumulates decimal
// digits, applies the binary suffix and registers one result per string.
// ----------------------------------------------------------------------------
module szp_back
   import szp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  szp_item_type           q_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SIZE_BITS-1:0]   rsp_size_value,
   output logic [STATUS_BITS-1:0] rsp_status
);

   localparam int WIDE_BITS = VALUE_BITS + 4;

   // Parse state.
   phase_type             phase_ff;
   phase_type             phase_in;
   logic [VALUE_BITS-1:0] acc_ff;
   logic [VALUE_BITS-1:0] acc_in;
   logic                  sat_ff;
   logic                  sat_in;
   logic                  neg_ff;
   logic                  neg_in;
   status_type            err_ff;
   status_type            err_in;

   // Result register; the value is held raw and closed on the way out.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_acc_ff;
   logic                  rsp_sat_ff;
   logic                  rsp_neg_ff;
   status_type            rsp_err_ff;

   // Step results.
   phase_type             tk_phase;
   logic [VALUE_BITS-1:0] tk_acc;
   logic                  tk_sat;
   logic                  tk_neg;
   status_type            tk_err;
   phase_type             end_phase;
   status_type            end_err;

   logic                  out_free;
   logic                  pop;
   logic                  ends;
   logic [WIDE_BITS-1:0]  mul10;
   logic                  mul_over;
   logic [VALUE_BITS-1:0] trail_src;
   logic                  is_scale;
   logic                  sc_over;
   logic [VALUE_BITS-1:0] sc_value;

   // One request is taken whenever the result register can take a result.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_ready  = out_free;
   assign pop      = q_valid && out_free;
   assign ends     = (q_item.cls == CLS_NUL) || q_item.last;

   // Multiply-by-ten accumulate with an overflow flag.
   always_comb begin
      mul10 = (WIDE_BITS'(acc_ff) << 3) + (WIDE_BITS'(acc_ff) << 1)
            + WIDE_BITS'(q_item.digit);
      mul_over = |mul10[WIDE_BITS-1:VALUE_BITS];
   end

   // Value that a suffix applies to: a digit run is closed first.
   assign trail_src = (phase_ff == PH_DIGITS) ? close_value(acc_ff, sat_ff, neg_ff)
                                              : acc_ff;

   // Suffix scaling with the range check.
   always_comb begin
      is_scale = 1'b1;
      case (q_item.cls)
         CLS_K: begin
            sc_over  = |trail_src[VALUE_BITS-1 -: SHIFT_K];
            sc_value = trail_src << SHIFT_K;
         end
         CLS_M: begin
            sc_over  = |trail_src[VALUE_BITS-1 -: SHIFT_M];
            sc_value = trail_src << SHIFT_M;
         end
         CLS_G: begin
            sc_over  = |trail_src[VALUE_BITS-1 -: SHIFT_G];
            sc_value = trail_src << SHIFT_G;
         end
         default: begin
            is_scale = 1'b0;
            sc_over  = 1'b0;
            sc_value = trail_src;
         end
      endcase
   end

   // Effect of one non-zero byte on the parse state.
   always_comb begin
      tk_phase = phase_ff;
      tk_acc   = acc_ff;
      tk_sat   = sat_ff;
      tk_neg   = neg_ff;
      tk_err   = err_ff;
      if (q_item.cls != CLS_NUL) begin
         unique case (phase_ff)
            PH_LEAD, PH_SIGN: begin
               if (phase_ff == PH_LEAD && q_item.cls == CLS_SPACE) begin
                  tk_phase = PH_LEAD;
               end else if (phase_ff == PH_LEAD &&
                            (q_item.cls == CLS_PLUS || q_item.cls == CLS_MINUS)) begin
                  tk_neg   = (q_item.cls == CLS_MINUS);
                  tk_phase = PH_SIGN;
               end else if (q_item.cls == CLS_DIGIT) begin
                  tk_acc   = VALUE_BITS'(q_item.digit);
                  tk_sat   = 1'b0;
                  tk_phase = PH_DIGITS;
               end else begin
                  tk_err   = ST_NO_DIGITS;
                  tk_phase = PH_DONE;
               end
            end
            PH_DIGITS, PH_TRAIL: begin
               if (phase_ff == PH_DIGITS && q_item.cls == CLS_DIGIT) begin
                  if (!sat_ff) begin
                     if (mul_over) begin
                        tk_sat = 1'b1;
                     end else begin
                        tk_acc = mul10[VALUE_BITS-1:0];
                     end
                  end
               end else begin
                  // The digit run is over: fold it and read the suffix.
                  tk_sat = 1'b0;
                  tk_neg = 1'b0;
                  tk_acc = trail_src;
                  if (q_item.cls == CLS_SPACE) begin
                     tk_phase = PH_TRAIL;
                  end else if (is_scale && sc_over) begin
                     tk_err   = ST_TOO_LARGE;
                     tk_phase = PH_DONE;
                  end else if (is_scale) begin
                     tk_acc   = sc_value;
                     tk_phase = PH_SUFFIX;
                  end else begin
                     tk_err   = ST_BAD_SUFFIX;
                     tk_phase = PH_DONE;
                  end
               end
            end
            PH_SUFFIX: begin
               if (q_item.cls == CLS_B) begin
                  tk_phase = PH_BYTE;
               end else begin
                  tk_err   = ST_BAD_SUFFIX;
                  tk_phase = PH_DONE;
               end
            end
            PH_BYTE: begin
               tk_err   = ST_BAD_SUFFIX;
               tk_phase = PH_DONE;
            end
            PH_DONE: begin
               tk_phase = PH_DONE;
            end
            default: begin
               tk_phase = PH_DONE;
            end
         endcase
      end
   end

   // End of string; an open digit run keeps its sign and saturation flags and
   // is closed at the result port.
   always_comb begin
      end_phase = tk_phase;
      end_err   = tk_err;
      if (ends && phase_ff != PH_DONE) begin
         end_phase = PH_DONE;
         if (tk_phase == PH_LEAD || tk_phase == PH_SIGN) begin
            end_err = ST_NO_DIGITS;
         end
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (pop) begin
         if (q_item.last) begin
            phase_in = PH_LEAD;
         end else begin
            phase_in = end_phase;
         end
      end
   end

   // Next datapath state and result handshake.
   always_comb begin
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         if (q_item.last) begin
            acc_in       = '0;
            sat_in       = 1'b0;
            neg_in       = 1'b0;
            err_in       = ST_OK;
            rsp_valid_in = 1'b1;
         end else begin
            acc_in = tk_acc;
            sat_in = tk_sat;
            neg_in = tk_neg;
            err_in = end_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         neg_ff       <= neg_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads with the last byte of a string.
   always_ff @(posedge clock) begin
      if (pop && q_item.last) begin
         rsp_acc_ff <= tk_acc;
         rsp_sat_ff <= tk_sat;
         rsp_neg_ff <= tk_neg;
         rsp_err_ff <= end_err;
      end
   end

   // Result port: the value is zero whenever the status reports an error.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_err_ff;
   assign rsp_size_value = (rsp_err_ff == ST_OK)
                         ? SIZE_BITS'(close_value(rsp_acc_ff, rsp_sat_ff, rsp_neg_ff))
                         : '0;

endmodule

// ===== rtl/core/size_with_suffix_parser.sv =====
// ----------------------------------------------------------------------------
// size_with_suffix_parser: decimal size string parser with binary suffix
// The last byte passes the front register and the queue before the back registers the result.
// It takes one byte per cycle while the back's result register is free or being read.
// The front register and the two-entry queue absorb result channel stalls.
// Reset (synchronous, active high) empties all stages and starts a new string.
// ----------------------------------------------------------------------------
module size_with_suffix_parser
   import szp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CHAR_BITS-1:0]   req_char_in,
   input  logic                   req_last_char,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SIZE_BITS-1:0]   rsp_size_value,
   output logic [STATUS_BITS-1:0] rsp_status
);

   logic         fr_valid;
   logic         fr_ready;
   szp_item_type fr_item;
   logic         q_valid;
   logic         q_ready;
   szp_item_type q_item;

   // Request intake and classification.
   szp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_in   (req_char_in),
      .req_last_char (req_last_char),
      .fr_valid      (fr_valid),
      .fr_ready      (fr_ready),
      .fr_item       (fr_item)
   );

   // Decoupling queue.
   szp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_item  (fr_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   // Parse state machine and result register.
   szp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_size_value (rsp_size_value),
      .rsp_status     (rsp_status)
   );

endmodule
